[src/ubd_pkg.sv]
// ----------------------------------------------------------------------------
// ubd_pkg: shared definitions for the radix digit converter
// Field widths, digit limits, and the digit-to-character mapping used by the
// converter, its divider, and its channel interfaces.
// ----------------------------------------------------------------------------
package ubd_pkg;

   // Field widths of the request and response items.
   localparam int VALUE_W  = 64;
   localparam int BASE_W   = 6;
   localparam int MIN_W    = 7;
   localparam int CHAR_W   = 7;
   localparam int TOTAL_W  = 7;

   // Digit storage limits.
   localparam int MAX_DIGITS = 64;
   localparam int CNT_W      = $clog2(MAX_DIGITS + 1);
   localparam int ADDR_W     = $clog2(MAX_DIGITS);
   localparam int DIGIT_W    = 6;

   // Divider step counter covers one step per dividend bit.
   localparam int STEP_W = $clog2(VALUE_W);

   // Radix limits and character codes.
   localparam logic [BASE_W-1:0]  RADIX_MIN    = BASE_W'(2);
   localparam logic [BASE_W-1:0]  RADIX_MAX    = BASE_W'(36);
   localparam logic [DIGIT_W-1:0] DECIMAL_SPAN = DIGIT_W'(10);
   localparam logic [CHAR_W-1:0]  CHAR_ZERO    = CHAR_W'(48);
   localparam logic [CHAR_W-1:0]  CHAR_LETTER  = CHAR_W'(65);

   // Control into the bit-serial divider.
   typedef struct packed {
      logic                start;
      logic [VALUE_W-1:0]  dividend;
      logic [BASE_W-1:0]   radix;
   } div_ctrl_type;

   // Result out of the bit-serial divider.
   typedef struct packed {
      logic                done;
      logic [VALUE_W-1:0]  quotient;
      logic [DIGIT_W-1:0]  remainder;
   } div_stat_type;

   // Map a digit value to its ASCII character: '0'-'9', then 'A'-'Z'.
   function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d);
      logic [CHAR_W-1:0] offset;
      if (d < DECIMAL_SPAN) begin
         offset = CHAR_ZERO;
      end else begin
         offset = CHAR_LETTER - CHAR_W'(DECIMAL_SPAN);
      end
      return CHAR_W'(d) + offset;
   endfunction

endpackage

[src/ubd_channels.sv]
// ----------------------------------------------------------------------------
// ubd_channels: request and response channels of the radix digit converter
// Each channel carries valid, ready and the payload; a transfer happens on a
// rising clock edge with valid and ready both high.
// ----------------------------------------------------------------------------
interface ubd_req_if;
   import ubd_pkg::*;

   logic                valid;
   logic                ready;
   logic [VALUE_W-1:0]  value;
   logic [BASE_W-1:0]   base;
   logic [MIN_W-1:0]    min_digits;

   modport source (output valid, output value, output base, output min_digits,
                   input ready);
   modport sink   (input valid, input value, input base, input min_digits,
                   output ready);
endinterface

interface ubd_rsp_if;
   import ubd_pkg::*;

   logic                valid;
   logic                ready;
   logic [CHAR_W-1:0]   digit_char;
   logic [TOTAL_W-1:0]  digit_total;
   logic                last_digit;

   modport source (output valid, output digit_char, output digit_total,
                   output last_digit, input ready);
   modport sink   (input valid, input digit_char, input digit_total,
                   input last_digit, output ready);
endinterface

[src/ubd_divider.sv]
// ----------------------------------------------------------------------------
// ubd_divider: bit-serial restoring divider by a small radix
// Shifts the dividend through one bit per cycle, building the quotient in the
// same shift register and keeping a narrow partial remainder.
// ----------------------------------------------------------------------------
module ubd_divider (
   input  logic                  clock,
   input  logic                  reset,
   input  ubd_pkg::div_ctrl_type ctrl,
   output ubd_pkg::div_stat_type stat
);
   import ubd_pkg::*;

   logic [VALUE_W-1:0] quot_ff, quot_in;
   logic [DIGIT_W-1:0] rem_ff, rem_in;
   logic [BASE_W-1:0]  radix_ff, radix_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;

   logic [DIGIT_W:0]   trial;
   logic               fits;

   // One restoring step: bring in the next dividend bit and subtract if it fits.
   assign trial = {rem_ff, quot_ff[VALUE_W-1]};
   assign fits  = trial >= {1'b0, radix_ff};

   always_comb begin
      quot_in  = quot_ff;
      rem_in   = rem_ff;
      radix_in = radix_ff;
      step_in  = step_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (ctrl.start) begin
         quot_in  = ctrl.dividend;
         rem_in   = '0;
         radix_in = ctrl.radix;
         step_in  = '0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         quot_in = {quot_ff[VALUE_W-2:0], fits};
         if (fits) begin
            rem_in = DIGIT_W'(trial - {1'b0, radix_ff});
         end else begin
            rem_in = trial[DIGIT_W-1:0];
         end
         step_in = step_ff + STEP_W'(1);
         if (step_ff == STEP_W'(VALUE_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quot_ff  <= quot_in;
      rem_ff   <= rem_in;
      radix_ff <= radix_in;
      step_ff  <= step_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign stat.done      = done_ff;
   assign stat.quotient  = quot_ff;
   assign stat.remainder = rem_ff;

endmodule

[src/ubd_digit_store.sv]
// ----------------------------------------------------------------------------
// ubd_digit_store: scratch memory for the collected digits
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ubd_digit_store (
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic [ubd_pkg::ADDR_W-1:0]   wr_addr,
   input  logic [ubd_pkg::DIGIT_W-1:0]  wr_data,
   input  logic                         rd_en,
   input  logic [ubd_pkg::ADDR_W-1:0]   rd_addr,
   output logic [ubd_pkg::DIGIT_W-1:0]  rd_data
);
   import ubd_pkg::*;

   logic [DIGIT_W-1:0] mem [MAX_DIGITS];
   logic [DIGIT_W-1:0] rd_data_ff;

   // Entries are always written before a conversion reads them back.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[src/uint_to_base_digits.sv]
// Each digit takes a serial division of the value (one dividend bit per
// cycle); pad digits are then written, and each digit is read from the
// store before it is offered. A new request is taken only once the last
// digit of the previous one has been accepted.
// Reset (synchronous, active high) returns the sequencer to idle; the digit
// store keeps its contents and needs no clearing pass.
// ----------------------------------------------------------------------------
// uint_to_base_digits: unsigned integer to ASCII digits in a chosen radix
// Divides the value by the radix one digit at a time, stores the remainders,
// pads with zeros up to the minimum count, and emits characters most
// significant first.
// ----------------------------------------------------------------------------
module uint_to_base_digits (
   input  logic      clock,
   input  logic      reset,
   ubd_req_if.sink   req_chan,
   ubd_rsp_if.source rsp_chan
);
   import ubd_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_PAD,
      ST_READ,
      ST_EMIT
   } state_type;

   localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_DIGITS);

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CNT_W-1:0]   min_ff, min_in;
   logic [BASE_W-1:0]  radix_ff, radix_in;
   logic [ADDR_W-1:0]  idx_ff, idx_in;

   div_ctrl_type       div_ctrl;
   div_stat_type       div_stat;

   logic               wr_en;
   logic [ADDR_W-1:0]  wr_addr;
   logic [DIGIT_W-1:0] wr_data;
   logic               rd_en;
   logic [DIGIT_W-1:0] rd_data;

   logic [BASE_W-1:0]  radix_clamped;
   logic [CNT_W-1:0]   min_clamped;
   logic               req_accept;

   // Clamp the radix to 2..36 and the minimum count to the store depth.
   always_comb begin
      if (req_chan.base < RADIX_MIN) begin
         radix_clamped = RADIX_MIN;
      end else if (req_chan.base > RADIX_MAX) begin
         radix_clamped = RADIX_MAX;
      end else begin
         radix_clamped = req_chan.base;
      end
      if (req_chan.min_digits > MIN_W'(MAX_DIGITS)) begin
         min_clamped = MAX_CNT;
      end else begin
         min_clamped = CNT_W'(req_chan.min_digits);
      end
   end

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_accept     = req_chan.valid && req_chan.ready;

   // Sequencer: divide, pad, then read the digits back in reverse order.
   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      min_in   = min_ff;
      radix_in = radix_ff;
      idx_in   = idx_ff;
      div_ctrl = '{start: 1'b0, dividend: div_stat.quotient, radix: radix_ff};
      wr_en    = 1'b0;
      wr_addr  = count_ff[ADDR_W-1:0];
      wr_data  = '0;
      rd_en    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               div_ctrl = '{start: 1'b1, dividend: req_chan.value, radix: radix_clamped};
               radix_in = radix_clamped;
               min_in   = min_clamped;
               count_in = '0;
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (div_stat.done) begin
               // Digits beyond the store depth are dropped from the top.
               if (count_ff < MAX_CNT) begin
                  wr_en    = 1'b1;
                  wr_data  = div_stat.remainder;
                  count_in = count_ff + CNT_W'(1);
               end
               if (div_stat.quotient == '0) begin
                  state_in = ST_PAD;
               end else begin
                  div_ctrl.start = 1'b1;
               end
            end
         end
         ST_PAD: begin
            if (count_ff < min_ff) begin
               wr_en    = 1'b1;
               count_in = count_ff + CNT_W'(1);
            end else begin
               idx_in   = ADDR_W'(count_ff - CNT_W'(1));
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            rd_en    = 1'b1;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (rsp_chan.ready) begin
               if (idx_ff == '0) begin
                  state_in = ST_IDLE;
               end else begin
                  idx_in   = idx_ff - ADDR_W'(1);
                  state_in = ST_READ;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      min_ff   <= min_in;
      radix_ff <= radix_in;
      idx_ff   <= idx_in;
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   ubd_divider u_divider (
      .clock (clock),
      .reset (reset),
      .ctrl  (div_ctrl),
      .stat  (div_stat)
   );

   ubd_digit_store u_digit_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (idx_ff),
      .rd_data (rd_data)
   );

   // The read data register holds the current digit while the response waits for ready.
   assign rsp_chan.valid       = (state_ff == ST_EMIT);
   assign rsp_chan.digit_char  = digit_to_ascii(rd_data);
   assign rsp_chan.digit_total = TOTAL_W'(count_ff);
   assign rsp_chan.last_digit  = (idx_ff == '0);

endmodule

[tb/uint_to_base_digits_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uint_to_base_digits_test: self-checking bench for the radix digit converter
// Drives a table of directed requests and then random ones through the request
// channel, predicts every ASCII digit that each request must produce, and
// compares the response stream field by field under random idling on both
// sides, one long response stall and two full drains of the converter.
// ----------------------------------------------------------------------------
module uint_to_base_digits_test;
   import ubd_pkg::*;

   localparam int TEXT_CHARS   = 20;
   localparam int CYCLE_LIMIT  = 4_000_000;
   localparam int RANDOM_COUNT = 118;
   localparam int HOLD_CYCLES  = 600;
   localparam int SETTLE_CYCLES = 300;
   localparam int MAX_IDLE     = 14;

   // One row of directed stimulus; a nonzero text gives the digits typed in.
   typedef struct packed {
      logic [VALUE_W-1:0]      value;
      logic [BASE_W-1:0]       base;
      logic [MIN_W-1:0]        min_digits;
      logic [8*TEXT_CHARS-1:0] text;
   } stim_row_type;

   // One predicted response.
   typedef struct packed {
      logic [CHAR_W-1:0]  digit_char;
      logic [TOTAL_W-1:0] digit_total;
      logic               last_digit;
   } digit_type;

   localparam int DIRECTED_COUNT = 22;
   localparam logic [VALUE_W-1:0] ALL_ONES = '1;
   localparam stim_row_type DIRECTED [DIRECTED_COUNT] = '{
      '{64'd0,            6'd10, 7'd0,   "0"},
      '{64'd0,            6'd10, 7'd5,   "00000"},
      '{64'd0,            6'd2,  7'd1,   "0"},
      '{64'd0,            6'd36, 7'd64,  ""},
      '{ALL_ONES,         6'd2,  7'd0,   ""},
      '{ALL_ONES,         6'd16, 7'd0,   "FFFFFFFFFFFFFFFF"},
      '{ALL_ONES,         6'd10, 7'd0,   "18446744073709551615"},
      '{ALL_ONES,         6'd36, 7'd0,   ""},
      '{64'h8000_0000_0000_0000, 6'd2, 7'd0, ""},
      '{64'd35,           6'd36, 7'd0,   "Z"},
      '{64'd255,          6'd16, 7'd0,   "FF"},
      '{64'd9,            6'd10, 7'd0,   "9"},
      '{64'd10,           6'd10, 7'd0,   "10"},
      '{64'd5,            6'd0,  7'd0,   "101"},
      '{64'd5,            6'd1,  7'd0,   "101"},
      '{64'd35,           6'd37, 7'd0,   "Z"},
      '{64'd1295,         6'd63, 7'd0,   "ZZ"},
      '{64'd1,            6'd10, 7'd64,  ""},
      '{64'd7,            6'd8,  7'd65,  ""},
      '{64'd1,            6'd10, 7'd127, ""},
      '{64'd123456,       6'd10, 7'd3,   "123456"},
      '{64'd12345,        6'd7,  7'd8,   ""}
   };

   logic clock;
   logic reset;

   ubd_req_if req_bus ();
   ubd_rsp_if rsp_bus ();

   uint_to_base_digits DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   digit_type pending_digits [$];
   int     mismatch_count;
   int     cycle_count;
   bit     no_idle;
   bit     hold_request;

   // Clock with a 4 ns period.
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Timeout guard.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles", $time, cycle_count);
         $display("uint_to_base_digits_test NOT OK");
         $finish;
      end
   end

   // Expand one request into its digits, most significant first, and queue them.
   task automatic expand_digits(input logic [VALUE_W-1:0] value,
                                input logic [BASE_W-1:0] base,
                                input logic [MIN_W-1:0] min_digits);
      logic [DIGIT_W-1:0] digits [MAX_DIGITS];
      logic [VALUE_W-1:0] quotient;
      logic [VALUE_W-1:0] radix;
      int                 minimum;
      int                 count;
      digit_type          d;
      radix = VALUE_W'(base);
      if (radix < VALUE_W'(RADIX_MIN)) radix = VALUE_W'(RADIX_MIN);
      if (radix > VALUE_W'(RADIX_MAX)) radix = VALUE_W'(RADIX_MAX);
      minimum = (int'(min_digits) > MAX_DIGITS) ? MAX_DIGITS : int'(min_digits);
      quotient = value;
      count = 0;
      // Collect remainders, least significant first.
      do begin
         if (count < MAX_DIGITS) begin
            digits[count] = DIGIT_W'(quotient % radix);
            count++;
         end
         quotient = quotient / radix;
      end while (quotient != 0);
      // Pad with zero digits up to the minimum.
      while (count < minimum) begin
         digits[count] = '0;
         count++;
      end
      for (int k = count - 1; k >= 0; k--) begin
         if (digits[k] < DECIMAL_SPAN)
            d.digit_char = CHAR_ZERO + CHAR_W'(digits[k]);
         else
            d.digit_char = CHAR_LETTER + CHAR_W'(digits[k] - DECIMAL_SPAN);
         d.digit_total = TOTAL_W'(count);
         d.last_digit  = (k == 0);
         pending_digits.push_back(d);
      end
   endtask

   // Offer one request after a random gap; queue its digits once accepted.
   task automatic send_request(input logic [VALUE_W-1:0] value,
                               input logic [BASE_W-1:0] base,
                               input logic [MIN_W-1:0] min_digits,
                               input logic [8*TEXT_CHARS-1:0] text);
      int        gap;
      int        length;
      digit_type d;
      gap = no_idle ? 0 : $urandom_range(0, MAX_IDLE);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.value      <= value;
      req_bus.base       <= base;
      req_bus.min_digits <= min_digits;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      if (text == '0) begin
         expand_digits(value, base, min_digits);
      end else begin
         // Typed-in digits: the text is right aligned, one character per byte.
         length = 0;
         for (int k = 0; k < TEXT_CHARS; k++)
            if (text[8*k +: 8] != 8'd0) length = k + 1;
         for (int k = length - 1; k >= 0; k--) begin
            d.digit_char  = CHAR_W'(text[8*k +: 8]);
            d.digit_total = TOTAL_W'(length);
            d.last_digit  = (k == 0);
            pending_digits.push_back(d);
         end
      end
   endtask

   // Stop offering and wait until every queued digit has come back.
   task automatic drain_converter();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (pending_digits.size() != 0);
   endtask

   // Response ready: random stall per digit, plus one long hold-off on demand.
   initial begin
      int stall;
      rsp_bus.ready = 1'b0;
      @(negedge reset);
      forever begin
         if (hold_request) begin
            stall = HOLD_CYCLES;
            hold_request = 1'b0;
         end else begin
            stall = no_idle ? 0 : $urandom_range(0, MAX_IDLE);
         end
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_bus.valid) @(posedge clock);
      end
   end

   // Compare each accepted digit with the oldest prediction.
   always @(posedge clock) begin
      digit_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_digits.size() == 0) begin
            $display("%0t: unexpected digit: expected none, got char %0d total %0d last %0b",
                     $time, rsp_bus.digit_char, rsp_bus.digit_total, rsp_bus.last_digit);
            mismatch_count++;
         end else begin
            want = pending_digits.pop_front();
            if (rsp_bus.digit_char !== want.digit_char) begin
               $display("%0t: digit_char mismatch: expected %0d, got %0d",
                        $time, want.digit_char, rsp_bus.digit_char);
               mismatch_count++;
            end
            if (rsp_bus.digit_total !== want.digit_total) begin
               $display("%0t: digit_total mismatch: expected %0d, got %0d",
                        $time, want.digit_total, rsp_bus.digit_total);
               mismatch_count++;
            end
            if (rsp_bus.last_digit !== want.last_digit) begin
               $display("%0t: last_digit mismatch: expected %0b, got %0b",
                        $time, want.last_digit, rsp_bus.last_digit);
               mismatch_count++;
            end
         end
      end
   end

   // Reset, directed table, random requests, then the final verdict.
   initial begin
      logic [VALUE_W-1:0] value;
      logic [BASE_W-1:0]  base;
      logic [MIN_W-1:0]   min_digits;
      mismatch_count     = 0;
      cycle_count        = 0;
      no_idle            = 1'b0;
      hold_request       = 1'b0;
      req_bus.valid      = 1'b0;
      req_bus.value      = '0;
      req_bus.base       = '0;
      req_bus.min_digits = '0;
      reset = 1'b1;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIRECTED_COUNT; i++)
         send_request(DIRECTED[i].value, DIRECTED[i].base,
                      DIRECTED[i].min_digits, DIRECTED[i].text);
      drain_converter();

      for (int i = 0; i < RANDOM_COUNT; i++) begin
         // A run of requests with no idling on either side.
         no_idle = (i >= 40 && i < 70);
         // Long response stall while requests keep coming.
         if (i == 20) hold_request = 1'b1;
         // Let the converter empty out completely once.
         if (i == 100) drain_converter();

         value = {$urandom, $urandom};
         if ($urandom_range(0, 3) != 0) value = value >> $urandom_range(0, 63);
         if ($urandom_range(0, 6) != 0) begin
            // Well-formed request: legal radix, modest padding.
            base       = BASE_W'($urandom_range(2, 36));
            min_digits = MIN_W'($urandom_range(0, 8));
         end else begin
            // Radix and padding over their full field ranges, out-of-range values included.
            base       = BASE_W'($urandom_range(0, 63));
            min_digits = MIN_W'($urandom_range(0, 127));
         end
         send_request(value, base, min_digits, '0);
      end
      req_bus.valid <= 1'b0;

      while (pending_digits.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("uint_to_base_digits_test OK");
      end else begin
         $display("uint_to_base_digits_test NOT OK");
      end
      $finish;
   end

endmodule
